/* hw/rtl/css_pkg.sv */
// Shared constants, command and status types for the clamped sample statistics block.
`timescale 1ns / 1ps

package css_pkg;

  // Sample width and default set size.
  localparam int SAMPLE_W      = 16;
  localparam int MAX_COUNT_DEF = 1024;

  // Fraction bits of the mean and standard deviation, and of the variance.
  localparam int FRAC_W     = 8;
  localparam int VAR_FRAC_W = 2 * FRAC_W;

  // Result field widths.
  localparam int COUNT_W = 11;
  localparam int MEAN_W  = 24;
  localparam int STD_W   = 24;

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 2;
  localparam int OUT_PAD_W  = OUT_DATA_W - (COUNT_W + 2 * SAMPLE_W + MEAN_W + STD_W);

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_ONLY   = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] CLAMP_LOW_RST  = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] CLAMP_HIGH_RST = 16'sd15;
  localparam logic                       POS_ONLY_RST   = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic mul_ld;
    logic diff_ld;
    logic div_start;
    logic div_var;
    logic mean_ld;
    logic sqrt_start;
    logic out_ld;
  } css_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic empty;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } css_sts_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIFF = 7'b0000100,
    S_MDIV = 7'b0001000,
    S_VDIV = 7'b0010000,
    S_SQRT = 7'b0100000,
    S_OUT  = 7'b1000000
  } css_state_t;

endpackage

/* hw/rtl/css_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module css_div #(
  parameter int DVD_W = 68,
  parameter int DVS_W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             ge;

  // The dividend register shifts out its top bit into the remainder and takes
  // the new quotient bit at the bottom.
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    trial   = shifted - {1'b0, dvs_r};
    rem_nxt = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

/* hw/rtl/css_sqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module css_sqrt #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic [W/2-1:0] root,
  output logic           done
);

  logic [W-1:0] x_r, x_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic [W-1:0] pw4_r;
  logic         busy_r;
  logic         done_r;
  logic [W:0]   trial;
  logic         ge;

  always_comb begin
    trial   = {1'b0, res_r} + {1'b0, pw4_r};
    ge      = {1'b0, x_r} >= trial;
    x_nxt   = ge ? (x_r - trial[W-1:0]) : x_r;
    res_nxt = ge ? ((res_r >> 1) + pw4_r) : (res_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && pw4_r[0]) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      res_r <= '0;
      pw4_r <= W'(1) << (W - 2);
    end else if (busy_r) begin
      x_r   <= x_nxt;
      res_r <= res_nxt;
      pw4_r <= pw4_r >> 2;
    end
  end

  assign root = res_r[W/2-1:0];
  assign done = done_r;

endmodule

/* hw/rtl/css_ctrl.sv */
// Sequencer that walks the end-of-set computation of the statistics block.
`timescale 1ns / 1ps

module css_ctrl
  import css_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_acc,
  input  logic     in_last,
  input  css_sts_t sts,
  output logic     in_ready,
  output css_cmd_t cmd
);

  css_state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.empty) begin
          state_nxt = S_OUT;
        end else begin
          cmd.mul_ld = 1'b1;
          state_nxt  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff_ld   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_MDIV;
      end
      S_MDIV: begin
        if (sts.div_done) begin
          cmd.mean_ld   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_var   = 1'b1;
          state_nxt     = S_VDIV;
        end
      end
      S_VDIV: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* hw/rtl/css_dp.sv */
// Datapath: configuration, clamping, accumulators, divider, square root, result register.
`timescale 1ns / 1ps

module css_dp
  import css_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic                       in_acc,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  css_cmd_t                   cmd,
  output css_sts_t                   sts,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser
);

  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int SUM_W = CNT_W + SAMPLE_W;
  localparam int SSQ_W = CNT_W + 2 * SAMPLE_W - 2;
  localparam int D_W   = CNT_W + SSQ_W;
  localparam int DVD_W = D_W + VAR_FRAC_W;
  localparam int DVS_W = 2 * CNT_W;
  localparam int Q_W   = 2 * SAMPLE_W + VAR_FRAC_W;

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] clamp_low_r;
  logic signed [SAMPLE_W-1:0] clamp_high_r;
  logic                       pos_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_low_r  <= CLAMP_LOW_RST;
      clamp_high_r <= CLAMP_HIGH_RST;
      pos_only_r   <= POS_ONLY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLAMP_LOW:  clamp_low_r  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_CLAMP_HIGH: clamp_high_r <= cfg_wdata[SAMPLE_W-1:0];
        CFG_POS_ONLY:   pos_only_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Accumulators.
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SSQ_W-1:0]           ssq_r;
  logic                       ovf_r;

  logic signed [SAMPLE_W-1:0] clamped;
  logic [SAMPLE_W-1:0]        mag;
  logic [2*SAMPLE_W-1:0]      sq;
  logic                       dropped;
  logic                       full;

  always_comb begin
    if (in_sample < clamp_low_r) begin
      clamped = clamp_low_r;
    end else if (in_sample > clamp_high_r) begin
      clamped = clamp_high_r;
    end else begin
      clamped = in_sample;
    end
    dropped = pos_only_r && (clamped[SAMPLE_W-1] || (clamped == '0));
    full    = cnt_r >= CNT_W'(MAX_COUNT);
    mag     = clamped[SAMPLE_W-1] ? (~clamped + 1'b1) : clamped;
    sq      = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_ld) begin
      cnt_r <= '0;
      min_r <= '0;
      max_r <= '0;
      sum_r <= '0;
      ssq_r <= '0;
      ovf_r <= 1'b0;
    end else if (in_acc && !dropped) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        if (cnt_r == '0 || clamped < min_r) min_r <= clamped;
        if (cnt_r == '0 || clamped > max_r) max_r <= clamped;
        sum_r <= sum_r + SUM_W'(clamped);
        ssq_r <= ssq_r + SSQ_W'(sq);
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // End-of-set products: n*sumsq, |sum|^2 and n^2.
  logic [SUM_W-1:0]   smag;
  logic [D_W-1:0]     prod_a;
  logic [2*SUM_W-1:0] prod_b;
  logic [DVS_W-1:0]   n_sq;
  logic [D_W-1:0]     prod_a_r;
  logic [D_W-1:0]     prod_b_r;
  logic [DVS_W-1:0]   n_sq_r;
  logic [D_W-1:0]     d_r;

  always_comb begin
    smag   = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
    prod_a = cnt_r * ssq_r;
    prod_b = smag * smag;
    n_sq   = cnt_r * cnt_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      prod_a_r <= prod_a;
      prod_b_r <= prod_b[D_W-1:0];
      n_sq_r   <= n_sq;
    end
    if (cmd.diff_ld) begin
      d_r <= prod_a_r - prod_b_r;
    end
  end

  // One divider serves the mean and then the scaled variance.
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] quot;
  logic             div_done;

  always_comb begin
    if (cmd.div_var) begin
      div_dvd = {d_r, {VAR_FRAC_W{1'b0}}};
      div_dvs = n_sq_r;
    end else begin
      div_dvd = DVD_W'({smag, {FRAC_W{1'b0}}});
      div_dvs = DVS_W'(cnt_r);
    end
  end

  css_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (quot),
    .done     (div_done)
  );

  logic [MEAN_W-1:0] mean_q;
  logic [MEAN_W-1:0] mean_r;

  assign mean_q = quot[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      mean_r <= sum_r[SUM_W-1] ? (~mean_q + 1'b1) : mean_q;
    end
  end

  logic [Q_W/2-1:0] root;
  logic             sqrt_done;

  css_sqrt #(
    .W (Q_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (quot[Q_W-1:0]),
    .root     (root),
    .done     (sqrt_done)
  );

  // Result register.
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0]    out_user_r;

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      if (cnt_r == '0) begin
        out_data_r <= '0;
        out_user_r <= {ovf_r, 1'b1};
      end else begin
        out_data_r <= {{OUT_PAD_W{1'b0}}, root[STD_W-1:0], mean_r, max_r, min_r,
                       cnt_ext[COUNT_W-1:0]};
        out_user_r <= {ovf_r, 1'b0};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sts.empty     = (cnt_r == '0);
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

/* hw/rtl/clamped_sample_statistics.sv */
// Clamped sample statistics: count, minimum, maximum, mean and standard deviation per set.
// Each input item carries one signed 16-bit sample. The sample is clamped to
// [clamp_low, clamp_high]; with positive_only set, a clamped value of zero or
// below is dropped. Kept samples update a count, minimum, maximum, sum and sum
// of squares; once MAX_COUNT samples are held, further kept samples are ignored
// and raise the overflow flag. The item with tlast set ends the set: after its
// sample is folded in, one result item is produced and the accumulators clear.
// The mean is sum*256/count truncated toward zero, and the standard deviation is
// floor(256*sqrt((n*sumsq - sum^2)/n^2)), both with 8 fraction bits. An empty
// set gives all-zero fields with empty_res set. An item without tlast does not
// stall the input. An item with tlast holds the input off until the end-of-set
// computation is done and its result is loaded; an empty set skips the divider
// and square root. The divider's dividend is 2*CNT_W + 46 bits and the radicand
// 48 bits, with CNT_W = clog2(MAX_COUNT+1). The computation uses one shared
// restoring divider, which gives one quotient bit per cycle and runs once for the
// mean and once for the variance, and the square root unit, which gives one
// result bit per cycle. The result sits in an output register, so a pending
// result does not keep the block from taking the next set's items; the sequencer
// waits only if a new result is ready while the previous one is still not taken.
`timescale 1ns / 1ps

module clamped_sample_statistics
  import css_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // Sample input.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                  in_tlast,
  // Result output.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [10:0] count, [26:11] minimum,
                                            // [42:27] maximum, [66:43] mean,
                                            // [90:67] std_dev, [95:91] zero
  output logic [OUT_USER_W-1:0] out_tuser   // [0] empty_res, [1] overflow
);

  css_cmd_t cmd;
  css_sts_t sts;
  logic     in_acc;

  // An item is taken when both sides of the input handshake agree.
  assign in_acc = in_tvalid && in_tready;

  css_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_last  (in_tlast),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  css_dp #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_acc     (in_acc),
    .in_sample  (in_tdata[SAMPLE_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/css_checker.sv */
// Port-level checks for the clamped sample statistics block, bound to the top level.
`timescale 1ns / 1ps

module css_checker
  import css_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // A result that is not taken stays offered with the same contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or dropped while stalled");

  // An item that does not end a set never stalls the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("input stalled after an item inside a set");

  // An item that ends a set stalls the input while the end-of-set computation runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after the last item of a set");

  // An empty set reports all-zero statistics.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("empty set result carries nonzero fields");

  // No result is offered right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind clamped_sample_statistics css_checker u_css_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
